// ----- hw/rtl/xncen_pkg.sv -----
package xncen_pkg;

	localparam int SLOTS       = 127;
	localparam int MAX_PAYLOAD = 64;
	localparam int STORE_BYTES = SLOTS * MAX_PAYLOAD;

	localparam int SW  = $clog2(SLOTS);
	localparam int SCW = $clog2(SLOTS + 1);
	localparam int PW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int PCW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW  = $clog2(STORE_BYTES);
	localparam int ZW  = $clog2(STORE_BYTES + 1);

	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_PACKET_LEN  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_GUARD_LEN   = 2'd1;
	localparam logic [CFG_IW-1:0] REG_OWN_NODE_ID = 2'd2;
	localparam logic [CFG_IW-1:0] REG_RELAY_ID    = 2'd3;

	localparam logic [2:0] TX_REQUEST = 3'd0;
	localparam logic [2:0] TX_BUFFER  = 3'd1;
	localparam logic [2:0] TX_HEADER  = 3'd2;
	localparam logic [2:0] TX_DATA    = 3'd3;
	localparam logic [2:0] TX_GUARD   = 3'd4;
	localparam logic [2:0] TX_ZEROS   = 3'd5;
	localparam logic [2:0] TX_SLEEP   = 3'd6;

	localparam logic [2:0] RX_IDLE   = 3'd0;
	localparam logic [2:0] RX_ID     = 3'd1;
	localparam logic [2:0] RX_NUMBER = 3'd2;
	localparam logic [2:0] RX_DATA   = 3'd3;
	localparam logic [2:0] RX_TAIL   = 3'd4;

	localparam logic [2:0] HDR_REPEAT     = 3'd3;
	localparam logic [2:0] HDR_LEN        = 3'd6;
	localparam logic [2:0] TAIL_LEN       = 3'd6;
	localparam logic [2:0] TAIL_MIN_ZEROS = 3'd4;
	localparam logic [7:0] NUMBER_WRAP    = 8'd254;

	typedef logic [7:0] byte_t;

	function automatic logic [SW-1:0] phys_row(input logic [SW-1:0] base,
		input logic [SCW-1:0] slot);
		logic [SCW:0] sum;
		sum = (SCW+1)'(base) + (SCW+1)'(slot);
		if (sum >= (SCW+1)'(SLOTS)) begin
			sum = sum - (SCW+1)'(SLOTS);
		end
		return sum[SW-1:0];
	endfunction

	function automatic logic [AW-1:0] paddr(input logic [SW-1:0] row,
		input logic [PW-1:0] col);
		return AW'(row) * AW'(MAX_PAYLOAD) + AW'(col);
	endfunction

endpackage

// ----- hw/rtl/xor_network_coding_end_node_core.sv -----
// Channel   Handshake                Payload
// step in   start & !busy            rx_byte, src_byte, src_valid, src_end
// result    done (one cycle)         tx_byte, decoded_byte, emitted, rx_taken, src_taken
// config    cfg_valid & cfg_ready    cfg_index, cfg_data
//
// An ordinary item steps load, run, transmit and receive; a source stall ends in load.
// A buffer scan has a read and a check state per slot, a shift a read and a write state per
// moved byte, and a packet load or a decode a read and a write state per payload byte.
// After reset a pass clears every store byte with busy high; config is taken throughout.
// The result is shown for exactly one cycle; busy is low in that cycle, so a new
// item may be started while it is shown.
module xor_network_coding_end_node_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  xncen_pkg::byte_t              rx_byte,
	input  xncen_pkg::byte_t              src_byte,
	input  logic                          src_valid,
	input  logic                          src_end,
	output logic                          done,
	output xncen_pkg::byte_t              tx_byte,
	output xncen_pkg::byte_t              decoded_byte,
	output logic                          emitted,
	output logic                          rx_taken,
	output logic                          src_taken,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [xncen_pkg::CFG_IW-1:0]  cfg_index,
	input  xncen_pkg::byte_t              cfg_data
);
	import xncen_pkg::*;

	localparam logic [4:0] S_CLR     = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_LOAD    = 5'd2;
	localparam logic [4:0] S_RUN     = 5'd3;
	localparam logic [4:0] S_TX      = 5'd4;
	localparam logic [4:0] S_SCAN_RD = 5'd5;
	localparam logic [4:0] S_SCAN_CK = 5'd6;
	localparam logic [4:0] S_SH_RD   = 5'd7;
	localparam logic [4:0] S_SH_WR   = 5'd8;
	localparam logic [4:0] S_BRD     = 5'd9;
	localparam logic [4:0] S_BCK     = 5'd10;
	localparam logic [4:0] S_LD_RD   = 5'd11;
	localparam logic [4:0] S_LD_WR   = 5'd12;
	localparam logic [4:0] S_RX      = 5'd13;
	localparam logic [4:0] S_DT_RD   = 5'd14;
	localparam logic [4:0] S_DT_CK   = 5'd15;
	localparam logic [4:0] S_DX_RD   = 5'd16;
	localparam logic [4:0] S_DX_WR   = 5'd17;

	// Memories
	byte_t sp_mem [STORE_BYTES];
	byte_t dp_mem [STORE_BYTES];
	byte_t op_mem [STORE_BYTES];
	byte_t sn_mem [SLOTS];
	byte_t dn_mem [SLOTS];
	byte_t cp_mem [MAX_PAYLOAD];
	byte_t st_mem [MAX_PAYLOAD];

	logic          sp_we, dp_we, op_we, sn_we, dn_we, cp_we, st_we;
	logic [AW-1:0] sp_wa, dp_wa, op_wa, sp_ra, dp_ra, op_ra;
	logic [SW-1:0] sn_wa, dn_wa, sn_ra, dn_ra;
	logic [PW-1:0] cp_wa, st_wa, cp_ra, st_ra;
	byte_t         sp_wd, dp_wd, op_wd, sn_wd, dn_wd, cp_wd, st_wd;
	byte_t         sp_rd, dp_rd, op_rd, sn_rd, dn_rd, cp_rd, st_rd;

	// Control registers
	logic [4:0]     st_q;
	logic [AW-1:0]  clr_q;
	logic [6:0]     plen_q;
	byte_t          glen_q, own_q, relay_q;
	byte_t          rx_q, sb_q;
	logic           sv_q, se_q;
	byte_t          tx_q, dec_q;
	logic           emit_q, rxt_q, srct_q, done_q;
	logic [2:0]     tx_ph_q, rx_ph_q;
	byte_t          npn_q;
	logic [SW-1:0]  slot_q, base_q, idx_q, sh_row_q, dx_phys_q;
	logic [PW-1:0]  sh_byte_q;
	logic [2:0]     req_pos_q, hdr_pos_q, tail_pos_q, tail_zeros_q;
	logic [PCW-1:0] pay_pos_q, load_pos_q, get_pos_q, run_pos_q, ld_i_q;
	logic [7:0]     grd_pos_q;
	logic [ZW-1:0]  zero_pos_q;
	logic [SCW-1:0] run_len_q, run_pkt_q;
	logic           run_act_q;
	logic [1:0]     id_pos_q, id_hits_q, num_pos_q;
	byte_t          num0_q, num1_q, coded_q;
	logic           confirmed_q, loading_q, loaded_q, src_done_q;

	// Derived values
	logic [PCW-1:0] len;
	logic [SW-1:0]  cur_phys, sh_phys, slot_inc;
	logic           ld_last, scan_end, dec_go;
	logic [SCW-1:0] scan_n;
	logic [ZW-1:0]  zero_nx, zero_thr;
	logic [8:0]     grd_nx;
	logic [1:0]     hits_nx, id_nx, num_nx;
	logic [2:0]     tz_nx, tp_nx;

	always_comb begin
		if (plen_q == 7'd0) begin
			len = PCW'(1);
		end else if (int'(plen_q) > MAX_PAYLOAD) begin
			len = PCW'(MAX_PAYLOAD);
		end else begin
			len = PCW'(plen_q);
		end
		cur_phys = phys_row(base_q, SCW'(slot_q));
		sh_phys  = phys_row(base_q, SCW'(sh_row_q));
		slot_inc = (slot_q == SW'(SLOTS - 1)) ? '0 : slot_q + 1'b1;
		ld_last  = (ld_i_q + 1'b1) >= len;
		scan_end = (dn_rd == 8'd0) || (idx_q == SW'(SLOTS - 1));
		scan_n   = (dn_rd == 8'd0) ? SCW'(idx_q) : SCW'(SLOTS);
		zero_nx  = zero_pos_q + 1'b1;
		zero_thr = ZW'(SLOTS) * ZW'(len);
		grd_nx   = {1'b0, grd_pos_q} + 9'd1;
		hits_nx  = id_hits_q + {1'b0, rx_q == relay_q};
		id_nx    = id_pos_q + 2'd1;
		num_nx   = num_pos_q + 2'd1;
		tz_nx    = tail_zeros_q + {2'b00, rx_q == 8'd0};
		tp_nx    = tail_pos_q + 3'd1;
		dec_go   = (rx_ph_q == RX_TAIL) && (tp_nx >= TAIL_LEN) && (tz_nx > TAIL_MIN_ZEROS);
	end

	always_comb begin
		sp_we = 1'b0; dp_we = 1'b0; op_we = 1'b0; sn_we = 1'b0;
		dn_we = 1'b0; cp_we = 1'b0; st_we = 1'b0;
		sp_wa = '0; dp_wa = '0; op_wa = '0; sn_wa = '0; dn_wa = '0; cp_wa = '0; st_wa = '0;
		sp_ra = '0; dp_ra = '0; op_ra = '0; sn_ra = '0; dn_ra = '0; cp_ra = '0; st_ra = '0;
		sp_wd = '0; dp_wd = '0; op_wd = '0; sn_wd = '0; dn_wd = '0; cp_wd = '0; st_wd = '0;
		case (st_q)
			S_CLR: begin
				sp_we = 1'b1; dp_we = 1'b1; op_we = 1'b1;
				sp_wa = clr_q; dp_wa = clr_q; op_wa = clr_q;
				sn_we = int'(clr_q) < SLOTS;
				dn_we = int'(clr_q) < SLOTS;
				sn_wa = clr_q[SW-1:0]; dn_wa = clr_q[SW-1:0];
				cp_we = int'(clr_q) < MAX_PAYLOAD;
				st_we = int'(clr_q) < MAX_PAYLOAD;
				cp_wa = clr_q[PW-1:0]; st_wa = clr_q[PW-1:0];
			end
			S_LOAD: begin
				op_ra = paddr(run_pkt_q[SW-1:0], run_pos_q[PW-1:0]);
				st_we = loading_q && !se_q && sv_q;
				st_wa = load_pos_q[PW-1:0];
				st_wd = sb_q;
			end
			S_RUN: begin
				sn_ra = cur_phys;
				dn_ra = cur_phys;
				sp_ra = paddr(cur_phys, pay_pos_q[PW-1:0]);
			end
			S_SCAN_RD: begin
				dn_ra = phys_row(base_q, SCW'(idx_q));
			end
			S_SH_RD: begin
				dp_ra = paddr(sh_phys, sh_byte_q);
				dp_we = 1'b1;
				dp_wa = paddr(sh_phys, sh_byte_q);
				sp_we = 1'b1;
				sp_wa = paddr(sh_phys, sh_byte_q);
				sn_we = sh_byte_q == '0;
				dn_we = sh_byte_q == '0;
				sn_wa = sh_phys;
				dn_wa = sh_phys;
			end
			S_SH_WR: begin
				op_we = 1'b1;
				op_wa = paddr(sh_row_q, sh_byte_q);
				op_wd = dp_rd;
			end
			S_BRD: begin
				sn_ra = cur_phys;
				dn_ra = cur_phys;
			end
			S_LD_RD: begin
				st_ra = ld_i_q[PW-1:0];
			end
			S_LD_WR: begin
				sp_we = 1'b1;
				sp_wa = paddr(cur_phys, ld_i_q[PW-1:0]);
				sp_wd = st_rd;
				sn_we = ld_last;
				sn_wa = cur_phys;
				sn_wd = npn_q;
			end
			S_RX: begin
				cp_we = rx_ph_q == RX_DATA;
				cp_wa = get_pos_q[PW-1:0];
				cp_wd = rx_q;
			end
			S_DT_RD: begin
				sn_ra = phys_row(base_q, SCW'(idx_q));
			end
			S_DX_RD: begin
				sp_ra = paddr(dx_phys_q, ld_i_q[PW-1:0]);
				cp_ra = ld_i_q[PW-1:0];
			end
			S_DX_WR: begin
				dp_we = 1'b1;
				dp_wa = paddr(dx_phys_q, ld_i_q[PW-1:0]);
				dp_wd = sp_rd ^ cp_rd;
				dn_we = ld_last;
				dn_wa = dx_phys_q;
				dn_wd = coded_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_wa] <= sp_wd;
		end
		sp_rd <= sp_mem[sp_ra];
	end

	always_ff @(posedge clk) begin
		if (dp_we) begin
			dp_mem[dp_wa] <= dp_wd;
		end
		dp_rd <= dp_mem[dp_ra];
	end

	always_ff @(posedge clk) begin
		if (op_we) begin
			op_mem[op_wa] <= op_wd;
		end
		op_rd <= op_mem[op_ra];
	end

	always_ff @(posedge clk) begin
		if (sn_we) begin
			sn_mem[sn_wa] <= sn_wd;
		end
		sn_rd <= sn_mem[sn_ra];
	end

	always_ff @(posedge clk) begin
		if (dn_we) begin
			dn_mem[dn_wa] <= dn_wd;
		end
		dn_rd <= dn_mem[dn_ra];
	end

	always_ff @(posedge clk) begin
		if (cp_we) begin
			cp_mem[cp_wa] <= cp_wd;
		end
		cp_rd <= cp_mem[cp_ra];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		st_rd <= st_mem[st_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0;
			plen_q <= 7'd64; glen_q <= 8'd6; own_q <= 8'd1; relay_q <= 8'd2;
			rx_q <= '0; sb_q <= '0; sv_q <= 1'b0; se_q <= 1'b0;
			tx_q <= '0; dec_q <= '0; emit_q <= 1'b0; rxt_q <= 1'b0; srct_q <= 1'b0;
			done_q <= 1'b0;
			tx_ph_q <= TX_REQUEST; rx_ph_q <= RX_IDLE; npn_q <= 8'd1;
			slot_q <= '0; base_q <= '0; idx_q <= '0; sh_row_q <= '0; dx_phys_q <= '0;
			sh_byte_q <= '0;
			req_pos_q <= '0; hdr_pos_q <= '0; tail_pos_q <= '0; tail_zeros_q <= '0;
			pay_pos_q <= '0; load_pos_q <= '0; get_pos_q <= '0; run_pos_q <= '0;
			ld_i_q <= '0; grd_pos_q <= '0; zero_pos_q <= '0;
			run_len_q <= '0; run_pkt_q <= '0; run_act_q <= 1'b0;
			id_pos_q <= '0; id_hits_q <= '0; num_pos_q <= '0;
			num0_q <= '0; num1_q <= '0; coded_q <= '0;
			confirmed_q <= 1'b0; loading_q <= 1'b1; loaded_q <= 1'b0; src_done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_PACKET_LEN: plen_q <= cfg_data[6:0];
					REG_GUARD_LEN: glen_q <= cfg_data;
					REG_OWN_NODE_ID: own_q <= cfg_data;
					REG_RELAY_ID: relay_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						rx_q <= rx_byte; sb_q <= src_byte;
						sv_q <= src_valid; se_q <= src_end;
						st_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					tx_q <= '0; dec_q <= '0; emit_q <= 1'b0; rxt_q <= 1'b1; srct_q <= 1'b0;
					st_q <= S_RUN;
					if (loading_q) begin
						if (se_q) begin
							src_done_q <= 1'b1;
							loading_q <= 1'b0;
						end else if (sv_q) begin
							srct_q <= 1'b1;
							if ((load_pos_q + 1'b1) >= len) begin
								loading_q <= 1'b0;
								loaded_q <= 1'b1;
								load_pos_q <= '0;
							end else begin
								load_pos_q <= load_pos_q + 1'b1;
							end
						end else begin
							rxt_q <= 1'b0;
							done_q <= 1'b1;
							st_q <= S_IDLE;
						end
					end
				end
				S_RUN: begin
					if (run_act_q && tx_ph_q != TX_BUFFER) begin
						if (run_pos_q < len) begin
							dec_q <= op_rd;
							run_pos_q <= run_pos_q + 1'b1;
						end else begin
							run_pos_q <= '0;
							run_pkt_q <= run_pkt_q + 1'b1;
							if ((run_pkt_q + 1'b1) >= run_len_q) begin
								run_act_q <= 1'b0;
							end else begin
								dec_q <= relay_q;
							end
						end
					end
					st_q <= S_TX;
				end
				S_TX: begin
					st_q <= S_RX;
					case (tx_ph_q)
						TX_REQUEST: begin
							tx_q <= (req_pos_q < HDR_REPEAT) ? own_q : 8'd0;
							emit_q <= 1'b1;
							if ((req_pos_q + 3'd1) >= HDR_LEN) begin
								req_pos_q <= '0;
								if (confirmed_q) begin
									tx_ph_q <= TX_BUFFER;
								end
							end else begin
								req_pos_q <= req_pos_q + 3'd1;
							end
						end
						TX_BUFFER: begin
							if (slot_q == '0) begin
								idx_q <= '0;
								st_q <= S_SCAN_RD;
							end else begin
								st_q <= S_BRD;
							end
						end
						TX_HEADER: begin
							tx_q <= (hdr_pos_q < HDR_REPEAT) ? own_q : sn_rd;
							emit_q <= 1'b1;
							if ((hdr_pos_q + 3'd1) >= HDR_LEN) begin
								hdr_pos_q <= '0;
								tx_ph_q <= TX_DATA;
							end else begin
								hdr_pos_q <= hdr_pos_q + 3'd1;
							end
						end
						TX_DATA: begin
							tx_q <= sp_rd;
							emit_q <= 1'b1;
							if ((pay_pos_q + 1'b1) >= len) begin
								pay_pos_q <= '0;
								tx_ph_q <= TX_GUARD;
							end else begin
								pay_pos_q <= pay_pos_q + 1'b1;
							end
						end
						TX_GUARD: begin
							tx_q <= '0;
							emit_q <= 1'b1;
							if (grd_nx >= {1'b0, glen_q}) begin
								grd_pos_q <= '0;
								slot_q <= slot_inc;
								tx_ph_q <= TX_BUFFER;
							end else begin
								grd_pos_q <= grd_nx[7:0];
							end
						end
						TX_ZEROS: begin
							tx_q <= '0;
							emit_q <= 1'b1;
							zero_pos_q <= zero_nx;
							if (zero_nx >= zero_thr) begin
								tx_ph_q <= TX_SLEEP;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN_RD: begin
					st_q <= S_SCAN_CK;
				end
				S_SCAN_CK: begin
					if (scan_end) begin
						if (scan_n != '0) begin
							run_len_q <= scan_n;
							run_act_q <= 1'b1;
							run_pkt_q <= '0;
							tx_q <= '0;
							dec_q <= relay_q;
							emit_q <= 1'b1;
							sh_row_q <= '0;
							sh_byte_q <= '0;
							st_q <= S_SH_RD;
						end else begin
							st_q <= S_BRD;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_SCAN_RD;
					end
				end
				S_SH_RD: begin
					st_q <= S_SH_WR;
				end
				S_SH_WR: begin
					st_q <= S_SH_RD;
					if (sh_byte_q == PW'(MAX_PAYLOAD - 1)) begin
						sh_byte_q <= '0;
						if ((SCW'(sh_row_q) + 1'b1) >= run_len_q) begin
							base_q <= phys_row(base_q, run_len_q);
							st_q <= S_BRD;
						end else begin
							sh_row_q <= sh_row_q + 1'b1;
						end
					end else begin
						sh_byte_q <= sh_byte_q + 1'b1;
					end
				end
				S_BRD: begin
					st_q <= S_BCK;
				end
				S_BCK: begin
					st_q <= S_RX;
					if (sn_rd == 8'd0) begin
						if (slot_q == '0 && src_done_q) begin
							tx_ph_q <= TX_ZEROS;
						end else if (loaded_q) begin
							ld_i_q <= '0;
							st_q <= S_LD_RD;
						end else begin
							slot_q <= '0;
						end
					end else if (dn_rd == 8'd0) begin
						tx_ph_q <= TX_HEADER;
					end else begin
						slot_q <= slot_inc;
					end
				end
				S_LD_RD: begin
					st_q <= S_LD_WR;
				end
				S_LD_WR: begin
					if (ld_last) begin
						if (!src_done_q) begin
							npn_q <= (npn_q >= NUMBER_WRAP) ? 8'd1 : npn_q + 8'd1;
							loading_q <= 1'b1;
						end else begin
							loading_q <= 1'b0;
							slot_q <= '0;
						end
						loaded_q <= 1'b0;
						tx_ph_q <= TX_HEADER;
						st_q <= S_RX;
					end else begin
						ld_i_q <= ld_i_q + 1'b1;
						st_q <= S_LD_RD;
					end
				end
				S_RX: begin
					if (dec_go) begin
						idx_q <= '0;
						st_q <= S_DT_RD;
					end else begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end
					case (rx_ph_q)
						RX_IDLE: begin
							if (rx_q == relay_q) begin
								rx_ph_q <= RX_ID;
								id_pos_q <= 2'd1;
								id_hits_q <= 2'd1;
							end
						end
						RX_ID: begin
							if (id_nx >= 2'd3) begin
								if (hits_nx == 2'd3) begin
									rx_ph_q <= RX_NUMBER;
								end else begin
									rx_ph_q <= RX_IDLE;
									rxt_q <= 1'b0;
								end
								id_pos_q <= '0;
								id_hits_q <= '0;
							end else begin
								id_pos_q <= id_nx;
								id_hits_q <= hits_nx;
							end
						end
						RX_NUMBER: begin
							if (num_pos_q == 2'd0) begin
								num0_q <= rx_q;
							end
							if (num_pos_q == 2'd1) begin
								num1_q <= rx_q;
							end
							if (num_nx >= 2'd3) begin
								num_pos_q <= '0;
								rx_ph_q <= RX_IDLE;
								if (num0_q == num1_q && num1_q == rx_q) begin
									if (rx_q == 8'd0) begin
										confirmed_q <= 1'b1;
									end else begin
										coded_q <= rx_q;
										rx_ph_q <= RX_DATA;
									end
								end
							end else begin
								num_pos_q <= num_nx;
							end
						end
						RX_DATA: begin
							if ((get_pos_q + 1'b1) >= len) begin
								get_pos_q <= '0;
								rx_ph_q <= RX_TAIL;
							end else begin
								get_pos_q <= get_pos_q + 1'b1;
							end
						end
						RX_TAIL: begin
							if (tp_nx >= TAIL_LEN) begin
								tail_pos_q <= '0;
								tail_zeros_q <= '0;
								rx_ph_q <= RX_IDLE;
							end else begin
								tail_pos_q <= tp_nx;
								tail_zeros_q <= tz_nx;
							end
						end
						default: begin
						end
					endcase
				end
				S_DT_RD: begin
					st_q <= S_DT_CK;
				end
				S_DT_CK: begin
					if (sn_rd == coded_q) begin
						dx_phys_q <= phys_row(base_q, SCW'(idx_q));
						ld_i_q <= '0;
						st_q <= S_DX_RD;
					end else if (idx_q == SW'(SLOTS - 1)) begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_DT_RD;
					end
				end
				S_DX_RD: begin
					st_q <= S_DX_WR;
				end
				S_DX_WR: begin
					if (ld_last) begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						ld_i_q <= ld_i_q + 1'b1;
						st_q <= S_DX_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = st_q != S_IDLE;
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign tx_byte      = emit_q ? tx_q : 8'd0;
	assign decoded_byte = emit_q ? dec_q : 8'd0;
	assign emitted      = emit_q;
	assign rx_taken     = rxt_q;
	assign src_taken    = srct_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted item did not make the block busy.");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(base_q) < SLOTS) && (int'(slot_q) < SLOTS))
		else $error("Slot pointer or ring base out of range.");

endmodule
